// ===== rtl/q24_pkg.sv =====
// Shared types and constants for the Q24.8 fixed-point ALU.
`default_nettype none
package q24_pkg;

   localparam int FRAC_BITS_DEFAULT = 8;

   localparam logic [3:0] MODE_ADD      = 4'd0;
   localparam logic [3:0] MODE_SUB      = 4'd1;
   localparam logic [3:0] MODE_MUL      = 4'd2;
   localparam logic [3:0] MODE_DIV      = 4'd3;
   localparam logic [3:0] MODE_INC      = 4'd4;
   localparam logic [3:0] MODE_DEC      = 4'd5;
   localparam logic [3:0] MODE_CMP      = 4'd6;
   localparam logic [3:0] MODE_FROM_INT = 4'd7;
   localparam logic [3:0] MODE_TO_INT   = 4'd8;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_OVF  = 2'd1;
   localparam logic [1:0] STATUS_DIV0 = 2'd2;

   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [3:0]         mode;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               less;
      logic               equal;
      logic               greater;
      logic [1:0]         status;
   } rsp_type;

   // sideband that rides along the divider pipeline
   typedef struct packed {
      logic    is_div;
      logic    neg;
      logic    div0;
      rsp_type rsp;
   } tag_type;

endpackage
`default_nettype wire

// ===== rtl/q24_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband tag.
`default_nettype none
module q24_div #(
   parameter int NUM_W = 40
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire q24_pkg::tag_type     in_tag,
   input  wire logic [NUM_W-1:0]     in_num,
   input  wire logic [31:0]          in_den,
   output logic                      out_valid,
   output q24_pkg::tag_type          out_tag,
   output logic [NUM_W-1:0]          out_quot
);

   logic             valid_ff [NUM_W+1];
   q24_pkg::tag_type tag_ff   [NUM_W+1];
   logic [NUM_W-1:0] nq_ff    [NUM_W+1];
   logic [31:0]      rem_ff   [NUM_W+1];
   logic [31:0]      den_ff   [NUM_W+1];

   always_comb begin
      valid_ff[0] = in_valid;
      tag_ff[0]   = in_tag;
      nq_ff[0]    = in_num;
      rem_ff[0]   = '0;
      den_ff[0]   = in_den;
   end

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic [32:0]      shifted;
      logic [33:0]      diff;
      logic [31:0]      rem_in;
      logic [NUM_W-1:0] nq_in;

      always_comb begin
         shifted = {rem_ff[i], nq_ff[i][NUM_W-1]};
         diff    = {1'b0, shifted} - {2'b00, den_ff[i]};
         if (!diff[33]) begin
            rem_in = diff[31:0];
            nq_in  = {nq_ff[i][NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            nq_in  = {nq_ff[i][NUM_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
         tag_ff[i+1] <= tag_ff[i];
         nq_ff[i+1]  <= nq_in;
         rem_ff[i+1] <= rem_in;
         den_ff[i+1] <= den_ff[i];
      end
   end

   assign out_valid = valid_ff[NUM_W];
   assign out_tag   = tag_ff[NUM_W];
   assign out_quot  = nq_ff[NUM_W];

endmodule
`default_nettype wire

// ===== rtl/q24_8_fixed_point_alu_core.sv =====
// Top level of the signed Q24.8 fixed-point ALU.
// Every operation passes the capture stage, stages 2 and 3, the one-bit-per-stage divider pipeline
// and the output register before rsp_valid goes high.
// Throughput: one operation per cycle; busy stays low.
// Reset: synchronous, clears the valid bits of all stages; data is not reset.
// The receiver cannot stall; each result is strobed for one cycle.
`default_nettype none
module q24_8_fixed_point_alu_core #(
   parameter int FRAC_BITS = q24_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire q24_pkg::req_type  req_data,
   output logic                   rsp_valid,
   output q24_pkg::rsp_type       rsp_data
);

   localparam int NUM_W = 32 + FRAC_BITS;
   localparam logic [32:0] BIAS33 = 33'((33'd1 << FRAC_BITS) - 33'd1);
   localparam logic [63:0] BIAS64 = 64'((64'd1 << FRAC_BITS) - 64'd1);

   assign busy = 1'b0;

   // stage 1: capture
   logic             s1_valid_ff;
   q24_pkg::req_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      s1_req_ff <= req_data;
   end

   // stage 2: simple ops, multiply, divider operand prep
   logic signed [31:0] a, b, addend;
   logic signed [32:0] sum, to_int_sum;
   logic signed [31:0] hi;
   logic [31:0]        abs_a, abs_b;
   q24_pkg::tag_type   tag_in;

   always_comb begin
      a = s1_req_ff.operand_a;
      b = s1_req_ff.operand_b;
      case (s1_req_ff.mode)
         q24_pkg::MODE_SUB: addend = -b;
         q24_pkg::MODE_INC: addend = 32'sd1;
         q24_pkg::MODE_DEC: addend = -32'sd1;
         default:           addend = b;
      endcase
      if (s1_req_ff.mode == q24_pkg::MODE_SUB) begin
         sum = {a[31], a} - {b[31], b};
      end else begin
         sum = {a[31], a} + {addend[31], addend};
      end
      to_int_sum = {a[31], a} + (a[31] ? BIAS33 : 33'd0);
      hi    = a >>> (31 - FRAC_BITS);
      abs_a = a[31] ? 32'(-a) : a;
      abs_b = b[31] ? 32'(-b) : b;

      tag_in        = '0;
      tag_in.neg    = a[31] ^ b[31];
      tag_in.div0   = (b == 32'sd0);
      case (s1_req_ff.mode)
         q24_pkg::MODE_ADD, q24_pkg::MODE_SUB, q24_pkg::MODE_INC, q24_pkg::MODE_DEC: begin
            if (sum[32] != sum[31]) begin
               tag_in.rsp.result = sum[32] ? q24_pkg::S32_MIN : q24_pkg::S32_MAX;
               tag_in.rsp.status = q24_pkg::STATUS_OVF;
            end else begin
               tag_in.rsp.result = sum[31:0];
            end
         end
         q24_pkg::MODE_CMP: begin
            tag_in.rsp.less    = (a < b);
            tag_in.rsp.equal   = (a == b);
            tag_in.rsp.greater = (a > b);
         end
         q24_pkg::MODE_FROM_INT: begin
            if (!(hi == 32'sd0 || hi == -32'sd1)) begin
               tag_in.rsp.result = a[31] ? q24_pkg::S32_MIN : q24_pkg::S32_MAX;
               tag_in.rsp.status = q24_pkg::STATUS_OVF;
            end else begin
               tag_in.rsp.result = a <<< FRAC_BITS;
            end
         end
         q24_pkg::MODE_TO_INT: tag_in.rsp.result = 32'(to_int_sum >>> FRAC_BITS);
         q24_pkg::MODE_DIV:    tag_in.is_div = 1'b1;
         default: ;
      endcase
   end

   logic               s2_valid_ff;
   logic               s2_mul_ff;
   q24_pkg::tag_type   s2_tag_ff;
   logic signed [63:0] s2_prod_ff;
   logic [NUM_W-1:0]   s2_num_ff;
   logic [31:0]        s2_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_mul_ff  <= (s1_req_ff.mode == q24_pkg::MODE_MUL);
      s2_tag_ff  <= tag_in;
      s2_prod_ff <= 64'(a) * 64'(b);
      s2_num_ff  <= {abs_a, {FRAC_BITS{1'b0}}};
      s2_den_ff  <= abs_b;
   end

   // stage 3: product scaling and clamp
   logic signed [63:0] scaled;
   q24_pkg::tag_type   tag_mul;

   always_comb begin
      scaled  = $signed(s2_prod_ff + (s2_prod_ff[63] ? BIAS64 : 64'd0)) >>> FRAC_BITS;
      tag_mul = s2_tag_ff;
      if (s2_mul_ff) begin
         if (scaled > 64'sd2147483647) begin
            tag_mul.rsp.result = q24_pkg::S32_MAX;
            tag_mul.rsp.status = q24_pkg::STATUS_OVF;
         end else if (scaled < -64'sd2147483648) begin
            tag_mul.rsp.result = q24_pkg::S32_MIN;
            tag_mul.rsp.status = q24_pkg::STATUS_OVF;
         end else begin
            tag_mul.rsp.result = scaled[31:0];
         end
      end
   end

   logic             s3_valid_ff;
   q24_pkg::tag_type s3_tag_ff;
   logic [NUM_W-1:0] s3_num_ff;
   logic [31:0]      s3_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_tag_ff <= tag_mul;
      s3_num_ff <= s2_num_ff;
      s3_den_ff <= s2_den_ff;
   end

   logic             dv_valid;
   q24_pkg::tag_type dv_tag;
   logic [NUM_W-1:0] dv_quot;

   q24_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_tag    (s3_tag_ff),
      .in_num    (s3_num_ff),
      .in_den    (s3_den_ff),
      .out_valid (dv_valid),
      .out_tag   (dv_tag),
      .out_quot  (dv_quot)
   );

   // output stage: quotient sign and clamp
   q24_pkg::rsp_type rsp_in;
   localparam logic [NUM_W-1:0] Q_MAX = NUM_W'(32'h7fff_ffff);
   localparam logic [NUM_W-1:0] Q_MIN = NUM_W'(32'h8000_0000);

   always_comb begin
      rsp_in = dv_tag.rsp;
      if (dv_tag.is_div) begin
         if (dv_tag.div0) begin
            rsp_in.result = '0;
            rsp_in.status = q24_pkg::STATUS_DIV0;
         end else if (dv_tag.neg) begin
            if (dv_quot > Q_MIN) begin
               rsp_in.result = q24_pkg::S32_MIN;
               rsp_in.status = q24_pkg::STATUS_OVF;
            end else begin
               rsp_in.result = ~dv_quot[31:0] + 32'd1;
            end
         end else begin
            if (dv_quot > Q_MAX) begin
               rsp_in.result = q24_pkg::S32_MAX;
               rsp_in.status = q24_pkg::STATUS_OVF;
            end else begin
               rsp_in.result = dv_quot[31:0];
            end
         end
      end
   end

   logic             rsp_valid_ff;
   q24_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_data.less, rsp_data.equal, rsp_data.greater}))
      else $error("compare flags not exclusive");
   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == q24_pkg::STATUS_DIV0) |-> rsp_data.result == 32'sd0)
      else $error("divide by zero result not zero");
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == q24_pkg::STATUS_OVF) |->
      (rsp_data.result == q24_pkg::S32_MAX || rsp_data.result == q24_pkg::S32_MIN))
      else $error("overflow without saturation");
   a_pipe_valid: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |=> ##(NUM_W) rsp_valid)
      else $error("item lost in pipeline");
`endif

endmodule
`default_nettype wire

// ===== verif/q24_alu_checker.sv =====
// Checker for the Q24.8 ALU: predicts each result from accepted transfers and compares.
`timescale 1ns / 1ps
module q24_alu_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire q24_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire q24_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending
);
   import q24_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;

   rsp_type alu_results_q[$];

   function automatic logic signed [31:0] sat32(input logic signed [95:0] v,
                                                inout logic [1:0] st);
      if (v > 96'sd2147483647) begin
         st = STATUS_OVF;
         return S32_MAX;
      end
      if (v < -96'sd2147483648) begin
         st = STATUS_OVF;
         return S32_MIN;
      end
      return v[31:0];
   endfunction

   function automatic rsp_type alu_predict(input req_type rq);
      rsp_type r;
      logic signed [95:0] a;
      logic signed [95:0] b;
      logic signed [95:0] one;
      logic [1:0] st;
      a = rq.operand_a;
      b = rq.operand_b;
      one = 96'sd1 <<< FRAC;
      st = STATUS_OK;
      r = '0;
      case (rq.mode)
         MODE_ADD: r.result = sat32(a + b, st);
         MODE_SUB: r.result = sat32(a - b, st);
         MODE_MUL: r.result = sat32((a * b) / one, st);
         MODE_DIV: begin
            if (b == 0) st = STATUS_DIV0;
            else r.result = sat32((a * one) / b, st);
         end
         MODE_INC: r.result = sat32(a + 1, st);
         MODE_DEC: r.result = sat32(a - 1, st);
         MODE_CMP: begin
            r.less = a < b;
            r.equal = a == b;
            r.greater = a > b;
         end
         MODE_FROM_INT: r.result = sat32(a * one, st);
         MODE_TO_INT: r.result = sat32(a / one, st);
         default: ;
      endcase
      r.status = st;
      return r;
   endfunction

   assign pending = alu_results_q.size();

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (start && !busy) alu_results_q.push_back(alu_predict(req_data));
         if (rsp_valid) begin
            if (alu_results_q.size() == 0) begin
               $error("unexpected result %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = alu_results_q.pop_front();
               if (e !== rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (e.result !== rsp_data.result)
                     $error("result exp %h got %h", e.result, rsp_data.result);
                  if (e.less !== rsp_data.less)
                     $error("less exp %b got %b", e.less, rsp_data.less);
                  if (e.equal !== rsp_data.equal)
                     $error("equal exp %b got %b", e.equal, rsp_data.equal);
                  if (e.greater !== rsp_data.greater)
                     $error("greater exp %b got %b", e.greater, rsp_data.greater);
                  if (e.status !== rsp_data.status)
                     $error("status exp %d got %d", e.status, rsp_data.status);
               end
            end
         end
      end
   end
endmodule

// ===== verif/q24_8_fixed_point_alu_core_tb.sv =====
// Testbench top for the Q24.8 ALU: directed and random operation stimulus, verdict.
`timescale 1ns / 1ps
module q24_8_fixed_point_alu_core_tb;
   import q24_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   q24_8_fixed_point_alu_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   q24_alu_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'd0;
         3: return $urandom_range(0, 1) ? 32'h0000_0100 : 32'hffff_ff00;
         4: return {{20{$urandom_range(0, 1) == 1}}, 12'($urandom)};
         5: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // hold one transfer until accepted, leaving start high for the next edge
   task automatic send(input logic [3:0] m, input logic [31:0] a, input logic [31:0] b);
      req_data <= '{mode: m, operand_a: a, operand_b: b};
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   int burst;
   int sent;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int m = 0; m < 16; m++) send(4'(m), 32'h7fff_ffff, 32'h7fff_ffff);
      send(MODE_ADD, 32'h8000_0000, 32'h8000_0000);
      send(MODE_SUB, 32'h8000_0000, 32'h0000_0001);
      send(MODE_MUL, 32'h8000_0000, 32'h8000_0000);
      send(MODE_DIV, 32'h0000_0500, 32'd0);
      send(MODE_DIV, 32'h8000_0000, 32'hffff_ffff);
      send(MODE_INC, 32'h7fff_ffff, 32'd0);
      send(MODE_DEC, 32'h8000_0000, 32'd0);
      send(MODE_CMP, 32'h8000_0000, 32'h7fff_ffff);
      send(MODE_TO_INT, 32'hffff_ff01, 32'd0);
      pause(3);
      sent = 0;
      while (sent < 850) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst; i++) begin
            send($urandom_range(0, 19) == 0 ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8)),
                 pick_operand(), pick_operand());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 50));
      end
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule
